// ===== hdl/ile_pkg.sv =====
`timescale 1ns / 1ps
package ile_pkg;

  localparam int CAPACITY = 64;
  localparam int SLOT_W   = $clog2(CAPACITY);
  // count, index and length share the 7-bit field width
  localparam int CNT_W    = 7;
  localparam int ACT_W    = 3;
  localparam int DATA_W   = 8;
  localparam int ST_W     = 2;

  localparam logic [CNT_W-1:0] CAP_COUNT = CNT_W'(CAPACITY);

  localparam logic [ACT_W-1:0] ACT_APPEND = 3'd0;
  localparam logic [ACT_W-1:0] ACT_INSERT = 3'd1;
  localparam logic [ACT_W-1:0] ACT_REMOVE = 3'd2;
  localparam logic [ACT_W-1:0] ACT_READ   = 3'd3;
  localparam logic [ACT_W-1:0] ACT_CLEAR  = 3'd4;

  localparam logic [ST_W-1:0] ST_OK        = 2'd0;
  localparam logic [ST_W-1:0] ST_BAD_INDEX = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL      = 2'd2;

  typedef enum logic [1:0] {
    DSRC_ZERO,
    DSRC_VALUE,
    DSRC_CHAR
  } dsrc_t;

  typedef struct packed {
    logic            take_in;
    logic            alloc;
    logic            walk_step;
    logic            fetch;
    logic            ins_first;
    logic            ins_head;
    logic            ins_tail;
    logic            link_new;
    logic            link_prev;
    logic            rem_fin;
    logic            clear;
    logic            data_ld;
    dsrc_t           data_src;
    logic            out_ld;
    logic [ST_W-1:0] out_status;
  } ile_cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             out_free;
  } ile_stat_t;

endpackage

// ===== hdl/ile_if.sv =====
`timescale 1ns / 1ps
interface ile_in_if import ile_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ACT_W-1:0]  action;
  logic [CNT_W-1:0]  index;
  logic [DATA_W-1:0] value;

  modport source (output valid, action, index, value, input ready);
  modport sink   (input valid, action, index, value, output ready);
endinterface

interface ile_out_if import ile_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ST_W-1:0]   status;
  logic [DATA_W-1:0] data_out;
  logic [CNT_W-1:0]  length;

  modport source (output valid, status, data_out, length, input ready);
  modport sink   (input valid, status, data_out, length, output ready);
endinterface

// ===== hdl/ile_datapath.sv =====
`timescale 1ns / 1ps
module ile_datapath import ile_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [DATA_W-1:0] in_value,
  input  ile_cmd_t          cmd,
  output ile_stat_t         stat,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [ST_W-1:0]   out_status,
  output logic [DATA_W-1:0] out_data,
  output logic [CNT_W-1:0]  out_length
);

  logic [DATA_W-1:0] char_mem  [CAPACITY];
  logic [SLOT_W-1:0] link_mem  [CAPACITY];
  logic [SLOT_W-1:0] stack_mem [CAPACITY];

  logic [DATA_W-1:0] char_q_r;
  logic [SLOT_W-1:0] link_q_r;
  logic [SLOT_W-1:0] stack_q_r;

  logic [SLOT_W-1:0] head_r, last_r, prev_r, victim_r, ns_r;
  logic [CNT_W-1:0]  count_r, sp_r, hw_r;
  logic              at_head_r;
  logic [DATA_W-1:0] val_r, res_data_r;
  logic              out_valid_r;
  logic [ST_W-1:0]   out_status_r;
  logic [DATA_W-1:0] out_data_r;
  logic [CNT_W-1:0]  out_length_r;

  logic [SLOT_W-1:0] cur;
  logic [SLOT_W-1:0] ns_pick;
  logic [CNT_W-1:0]  sp_dec;
  logic              link_we;
  logic [SLOT_W-1:0] link_waddr, link_wdata;

  // slot at the current walk position
  assign cur     = at_head_r ? head_r : link_q_r;
  // recycled slots first, then never-used ones
  assign ns_pick = (sp_r != '0) ? stack_q_r : hw_r[SLOT_W-1:0];
  assign sp_dec  = sp_r - 1'b1;

  always_comb begin
    link_we    = 1'b0;
    link_waddr = ns_r;
    link_wdata = head_r;
    priority if (cmd.ins_head) begin
      link_we    = 1'b1;
      link_waddr = ns_r;
      link_wdata = head_r;
    end else if (cmd.ins_tail) begin
      link_we    = 1'b1;
      link_waddr = last_r;
      link_wdata = ns_r;
    end else if (cmd.link_new) begin
      link_we    = 1'b1;
      link_waddr = ns_r;
      link_wdata = cur;
    end else if (cmd.link_prev) begin
      link_we    = 1'b1;
      link_waddr = prev_r;
      link_wdata = ns_r;
    end else if (cmd.rem_fin && !at_head_r) begin
      link_we    = 1'b1;
      link_waddr = prev_r;
      link_wdata = link_q_r;
    end else begin
      link_we    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    if (cmd.walk_step || cmd.fetch) begin
      link_q_r <= link_mem[cur];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.alloc) begin
      char_mem[ns_pick] <= val_r;
    end
    if (cmd.fetch) begin
      char_q_r <= char_mem[cur];
    end
  end

  // free slot stack, top always read out
  always_ff @(posedge clk) begin
    if (cmd.rem_fin) begin
      stack_mem[sp_r[SLOT_W-1:0]] <= victim_r;
    end
    stack_q_r <= stack_mem[sp_dec[SLOT_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      last_r      <= '0;
      count_r     <= '0;
      sp_r        <= '0;
      hw_r        <= '0;
      at_head_r   <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.take_in) begin
        at_head_r <= 1'b1;
      end
      if (cmd.walk_step) begin
        at_head_r <= 1'b0;
      end
      if (cmd.alloc) begin
        if (sp_r != '0) begin
          sp_r <= sp_r - 1'b1;
        end else begin
          hw_r <= hw_r + 1'b1;
        end
      end
      if (cmd.ins_first) begin
        head_r  <= ns_r;
        last_r  <= ns_r;
        count_r <= count_r + 1'b1;
      end
      if (cmd.ins_head) begin
        head_r  <= ns_r;
        count_r <= count_r + 1'b1;
      end
      if (cmd.ins_tail) begin
        last_r  <= ns_r;
        count_r <= count_r + 1'b1;
      end
      if (cmd.link_prev) begin
        count_r <= count_r + 1'b1;
      end
      if (cmd.rem_fin) begin
        sp_r    <= sp_r + 1'b1;
        count_r <= count_r - 1'b1;
        if (count_r == CNT_W'(1)) begin
          head_r <= '0;
          last_r <= '0;
        end else if (at_head_r) begin
          head_r <= link_q_r;
        end else if (victim_r == last_r) begin
          last_r <= prev_r;
        end
      end
      if (cmd.clear) begin
        head_r  <= '0;
        last_r  <= '0;
        count_r <= '0;
        sp_r    <= '0;
        hw_r    <= '0;
      end
      if (cmd.out_ld) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_in) begin
      val_r <= in_value;
    end
    if (cmd.walk_step) begin
      prev_r <= cur;
    end
    if (cmd.fetch) begin
      victim_r <= cur;
    end
    if (cmd.alloc) begin
      ns_r <= ns_pick;
    end
    if (cmd.data_ld) begin
      unique case (cmd.data_src)
        DSRC_VALUE: res_data_r <= val_r;
        DSRC_CHAR:  res_data_r <= char_q_r;
        default:    res_data_r <= '0;
      endcase
    end
    if (cmd.out_ld) begin
      out_status_r <= cmd.out_status;
      out_data_r   <= res_data_r;
      out_length_r <= count_r;
    end
  end

  assign stat.count    = count_r;
  assign stat.out_free = !out_valid_r || out_ready;

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_data   = out_data_r;
  assign out_length = out_length_r;

endmodule

// ===== hdl/ile_ctrl.sv =====
`timescale 1ns / 1ps
module ile_ctrl import ile_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [ACT_W-1:0] in_action,
  input  logic [CNT_W-1:0] in_index,
  input  ile_stat_t        stat,
  output ile_cmd_t         cmd
);

  localparam int STATE_W = 4;
  localparam logic [STATE_W-1:0] S_IDLE   = 4'd0;
  localparam logic [STATE_W-1:0] S_DECODE = 4'd1;
  localparam logic [STATE_W-1:0] S_PLACE  = 4'd2;
  localparam logic [STATE_W-1:0] S_WALK   = 4'd3;
  localparam logic [STATE_W-1:0] S_LNEW   = 4'd4;
  localparam logic [STATE_W-1:0] S_LPREV  = 4'd5;
  localparam logic [STATE_W-1:0] S_FETCH  = 4'd6;
  localparam logic [STATE_W-1:0] S_REM    = 4'd7;
  localparam logic [STATE_W-1:0] S_RDFIN  = 4'd8;
  localparam logic [STATE_W-1:0] S_FINISH = 4'd9;

  logic [STATE_W-1:0] state_r, state_nxt;
  logic [ACT_W-1:0]   act_r, act_nxt;
  logic [CNT_W-1:0]   pos_r, pos_nxt;
  logic [ST_W-1:0]    status_r, status_nxt;

  always_comb begin
    state_nxt  = state_r;
    act_nxt    = act_r;
    pos_nxt    = pos_r;
    status_nxt = status_r;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take_in = 1'b1;
          act_nxt     = in_action;
          pos_nxt     = in_index;
          status_nxt  = ST_OK;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.data_ld  = 1'b1;
        cmd.data_src = DSRC_ZERO;
        state_nxt    = S_FINISH;
        unique case (act_r)
          ACT_APPEND, ACT_INSERT: begin
            if (act_r == ACT_INSERT && pos_r > stat.count) begin
              status_nxt = ST_BAD_INDEX;
            end else if (stat.count == CAP_COUNT) begin
              status_nxt = ST_FULL;
            end else begin
              cmd.alloc    = 1'b1;
              cmd.data_src = DSRC_VALUE;
              state_nxt    = S_PLACE;
              if (act_r == ACT_APPEND) begin
                pos_nxt = stat.count;
              end
            end
          end
          ACT_REMOVE, ACT_READ: begin
            if (pos_r >= stat.count) begin
              status_nxt = ST_BAD_INDEX;
            end else begin
              state_nxt = S_WALK;
            end
          end
          ACT_CLEAR: begin
            cmd.clear = 1'b1;
          end
          default: begin
            cmd.data_src = DSRC_ZERO;
          end
        endcase
      end
      S_PLACE: begin
        priority if (stat.count == '0) begin
          cmd.ins_first = 1'b1;
          state_nxt     = S_FINISH;
        end else if (pos_r == '0) begin
          cmd.ins_head = 1'b1;
          state_nxt    = S_FINISH;
        end else if (pos_r == stat.count) begin
          cmd.ins_tail = 1'b1;
          state_nxt    = S_FINISH;
        end else begin
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        // one link per cycle from the head
        if (pos_r != '0) begin
          cmd.walk_step = 1'b1;
          pos_nxt       = pos_r - 1'b1;
        end else if (act_r == ACT_INSERT) begin
          state_nxt = S_LNEW;
        end else begin
          state_nxt = S_FETCH;
        end
      end
      S_LNEW: begin
        cmd.link_new = 1'b1;
        state_nxt    = S_LPREV;
      end
      S_LPREV: begin
        cmd.link_prev = 1'b1;
        state_nxt     = S_FINISH;
      end
      S_FETCH: begin
        cmd.fetch = 1'b1;
        state_nxt = (act_r == ACT_REMOVE) ? S_REM : S_RDFIN;
      end
      S_REM: begin
        cmd.rem_fin  = 1'b1;
        cmd.data_ld  = 1'b1;
        cmd.data_src = DSRC_CHAR;
        state_nxt    = S_FINISH;
      end
      S_RDFIN: begin
        cmd.data_ld  = 1'b1;
        cmd.data_src = DSRC_CHAR;
        state_nxt    = S_FINISH;
      end
      S_FINISH: begin
        // wait only if the previous result is still held
        if (stat.out_free) begin
          cmd.out_ld     = 1'b1;
          cmd.out_status = status_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r    <= act_nxt;
    pos_r    <= pos_nxt;
    status_r <= status_nxt;
  end

endmodule

// ===== hdl/indexed_list_engine.sv =====
`timescale 1ns / 1ps
// Indexed list engine: holds an ordered list of up to 64 characters as linked
// nodes in on-chip memory and serves one request per transaction (append,
// insert, remove or read at an index, clear), returning one result with a
// status, a character and the list length. Requests are handled one at a
// time; the input is ready again once the previous result sits in the output
// register. Clear, bad-index, full and unused-action requests go from decode
// straight to the result; append and insert at the head or tail link the new
// node directly. Insert in the middle, remove and read walk the link memory
// from the head one node per cycle (one registered link read per step), so
// their time grows with the index. A stalled output delays the result.
module indexed_list_engine import ile_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  ile_in_if.sink   in_chan,
  ile_out_if.source out_chan
);

  ile_cmd_t  cmd;
  ile_stat_t stat;

  ile_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .in_action(in_chan.action),
    .in_index (in_chan.index),
    .stat     (stat),
    .cmd      (cmd)
  );

  ile_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_value  (in_chan.value),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .out_status(out_chan.status),
    .out_data  (out_chan.data_out),
    .out_length(out_chan.length)
  );

endmodule
